// File: src/class_mean_spectrum_accumulator_macros.svh
// Assertion macros for the class mean spectrum accumulator.
// Used by the top level only; needs no package.
`ifndef CLASS_MEAN_SPECTRUM_ACCUMULATOR_MACROS_SVH
`define CLASS_MEAN_SPECTRUM_ACCUMULATOR_MACROS_SVH

// same-cycle implication
`define CMSA_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cmsa assertion failed");

// next-cycle implication
`define CMSA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cmsa assertion failed");

`endif

// File: src/cmsa_pkg.sv
// Shared types and codes of the class mean spectrum accumulator.
// No dependencies.
`default_nettype none

package cmsa_pkg;

    localparam logic OP_ACC  = 1'b0;
    localparam logic OP_READ = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    localparam int OUT_COUNT_W = 20;
    localparam int MEAN_W      = 8;

    typedef struct packed {
        logic sum_we;
        logic cnt_we;
    } t_store_ctl;

endpackage

`default_nettype wire

// File: src/cmsa_store.sv
// Band sum and class count memories, single port, registered read.
// Depends on cmsa_pkg.
`default_nettype none

module cmsa_store import cmsa_pkg::*; #(
    parameter int CLASSES = 32,
    parameter int BANDS   = 256,
    parameter int SUM_W   = 28,
    parameter int CNT_W   = 20
) (
    input  wire logic                                 i_clk,
    input  wire t_store_ctl                           i_ctl,
    input  wire logic [$clog2(CLASSES*BANDS)-1:0]     i_sum_addr,
    input  wire logic [SUM_W-1:0]                     i_sum_wdata,
    input  wire logic [$clog2(CLASSES)-1:0]           i_cnt_addr,
    input  wire logic [CNT_W-1:0]                     i_cnt_wdata,
    output logic      [SUM_W-1:0]                     o_sum_rdata,
    output logic      [CNT_W-1:0]                     o_cnt_rdata
);

    localparam int DEPTH = CLASSES * BANDS;

    logic [SUM_W-1:0] r_sum_mem [DEPTH];
    logic [CNT_W-1:0] r_cnt_mem [CLASSES];
    logic [SUM_W-1:0] r_sum_rd;
    logic [CNT_W-1:0] r_cnt_rd;

    always_ff @(posedge i_clk) begin
        if (i_ctl.sum_we) begin
            r_sum_mem[i_sum_addr] <= i_sum_wdata;
        end
        r_sum_rd <= r_sum_mem[i_sum_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.cnt_we) begin
            r_cnt_mem[i_cnt_addr] <= i_cnt_wdata;
        end
        r_cnt_rd <= r_cnt_mem[i_cnt_addr];
    end

    assign o_sum_rdata = r_sum_rd;
    assign o_cnt_rdata = r_cnt_rd;

endmodule

`default_nettype wire

// File: src/cmsa_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on cmsa_pkg.
`default_nettype none

module cmsa_div import cmsa_pkg::*; #(
    parameter int DVD_W = 28,
    parameter int DVS_W = 20
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [DVD_W-1:0]  i_dividend,
    input  wire logic [DVS_W-1:0]  i_divisor,
    output logic                   o_done,
    output logic      [DVD_W-1:0]  o_quotient
);

    localparam int STEP_W = $clog2(DVD_W + 1);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [DVS_W-1:0]  r_rem;
    logic [DVD_W-1:0]  r_quo;
    logic [DVS_W-1:0]  r_dvs;

    logic [DVS_W:0]    rem_sh;
    logic [DVS_W+1:0]  diff;
    logic              ge;

    assign rem_sh = {r_rem, r_quo[DVD_W-1]};
    assign diff   = {1'b0, rem_sh} - {2'b00, r_dvs};
    assign ge     = !diff[DVS_W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == STEP_W'(DVD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= ge ? diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
            r_quo <= {r_quo[DVD_W-2:0], ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

// File: src/class_mean_spectrum_accumulator.sv
// Top level: sequencer for accumulate and mean-read words over shared store and divider.
// Depends on cmsa_pkg, cmsa_store, cmsa_div and the assertion macro header.
//
// channel   direction  handshake         fields
// command   in         start / busy      operation, class_label, band_index, sample
// result    out        o_valid strobe    mean_value, pixel_count, status
//
// Accumulate: accept, memory read, write back.
// Read of a non-empty class: accept, memory read, then division in the bit-serial divider.
// Read of an empty class: accept, memory read, then the empty status is strobed.
// Read out of range: result strobed on the next cycle.
// After reset the sum and count stores are swept to zero with busy high.
// Results are strobed for one cycle; the receiver cannot stall.
`default_nettype none
`include "class_mean_spectrum_accumulator_macros.svh"

module class_mean_spectrum_accumulator import cmsa_pkg::*; #(
    parameter int CLASSES    = 32,
    parameter int BANDS      = 256,
    parameter int COUNT_BITS = 20
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    start,
    output logic                         busy,
    input  wire logic                    i_operation,
    input  wire logic [7:0]              i_class_label,
    input  wire logic [7:0]              i_band_index,
    input  wire logic [7:0]              i_sample,
    output logic                         o_valid,
    output logic      [MEAN_W-1:0]       o_mean_value,
    output logic      [OUT_COUNT_W-1:0]  o_pixel_count,
    output logic      [1:0]              o_status
);

    localparam int SUM_W  = COUNT_BITS + 8;
    localparam int DEPTH  = CLASSES * BANDS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CLS_W  = $clog2(CLASSES);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_LOAD  = 3'd2;
    localparam logic [2:0] S_CALC  = 3'd3;
    localparam logic [2:0] S_DIV   = 3'd4;

    logic [2:0]             r_state, n_state;
    logic [ADDR_W-1:0]      r_clr;
    logic                   r_op;
    logic [7:0]             r_cls;
    logic [7:0]             r_band;
    logic [7:0]             r_sample;
    logic [ADDR_W-1:0]      r_addr;

    logic                   r_valid, n_valid;
    logic [MEAN_W-1:0]      r_mean, n_mean;
    logic [OUT_COUNT_W-1:0] r_pcnt, n_pcnt;
    logic [1:0]             r_status, n_status;

    t_store_ctl             st_ctl;
    logic [ADDR_W-1:0]      sum_addr;
    logic [SUM_W-1:0]       sum_wdata;
    logic [CLS_W-1:0]       cnt_addr;
    logic [COUNT_BITS-1:0]  cnt_wdata;
    logic [SUM_W-1:0]       sum_rd;
    logic [COUNT_BITS-1:0]  cnt_rd;

    logic                   div_start;
    logic                   div_done;
    logic [SUM_W-1:0]       quotient;

    logic                   accept;
    logic                   in_range;
    logic                   clr_cls;
    logic [SUM_W:0]         sum_add;
    logic [SUM_W-1:0]       sum_sat;
    logic [32:0]            cnt_ext;
    logic [OUT_COUNT_W-1:0] cnt_out;

    assign accept   = start && !busy;
    assign in_range = ({1'b0, i_class_label} < 9'(CLASSES))
                   && ({1'b0, i_band_index} < 9'(BANDS));
    assign clr_cls  = {1'b0, r_clr} < (ADDR_W+1)'(CLASSES);

    assign sum_add  = {1'b0, sum_rd} + (SUM_W+1)'(r_sample);
    assign sum_sat  = sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];

    assign cnt_ext  = 33'(cnt_rd);
    assign cnt_out  = (cnt_ext > 33'({OUT_COUNT_W{1'b1}})) ? {OUT_COUNT_W{1'b1}}
                                                           : cnt_ext[OUT_COUNT_W-1:0];

    cmsa_store #(
        .CLASSES (CLASSES),
        .BANDS   (BANDS),
        .SUM_W   (SUM_W),
        .CNT_W   (COUNT_BITS)
    ) u_store (
        .i_clk       (i_clk),
        .i_ctl       (st_ctl),
        .i_sum_addr  (sum_addr),
        .i_sum_wdata (sum_wdata),
        .i_cnt_addr  (cnt_addr),
        .i_cnt_wdata (cnt_wdata),
        .o_sum_rdata (sum_rd),
        .o_cnt_rdata (cnt_rd)
    );

    cmsa_div #(
        .DVD_W (SUM_W),
        .DVS_W (COUNT_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (sum_rd),
        .i_divisor  (cnt_rd),
        .o_done     (div_done),
        .o_quotient (quotient)
    );

    always_comb begin
        n_state    = r_state;
        st_ctl     = '0;
        sum_addr   = r_addr;
        sum_wdata  = sum_sat;
        cnt_addr   = r_cls[CLS_W-1:0];
        cnt_wdata  = cnt_rd + 1'b1;
        div_start  = 1'b0;
        n_valid    = 1'b0;
        n_mean     = '0;
        n_pcnt     = '0;
        n_status   = ST_OK;
        case (r_state)
            S_CLEAR: begin
                st_ctl.sum_we = 1'b1;
                st_ctl.cnt_we = clr_cls;
                sum_addr      = r_clr;
                sum_wdata     = '0;
                cnt_addr      = r_clr[CLS_W-1:0];
                cnt_wdata     = '0;
                if (r_clr == ADDR_W'(DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    if (in_range) begin
                        n_state = S_LOAD;
                    end else if (i_operation == OP_READ) begin
                        n_valid  = 1'b1;
                        n_status = ST_RANGE;
                    end
                end
            end
            S_LOAD: begin
                n_state = S_CALC;
            end
            S_CALC: begin
                if (r_op == OP_ACC) begin
                    st_ctl.sum_we = 1'b1;
                    st_ctl.cnt_we = (r_band == 8'd0) && (cnt_rd != {COUNT_BITS{1'b1}});
                    n_state       = S_IDLE;
                end else if (cnt_rd == '0) begin
                    n_valid  = 1'b1;
                    n_status = ST_EMPTY;
                    n_state  = S_IDLE;
                end else begin
                    div_start = 1'b1;
                    n_state   = S_DIV;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_valid  = 1'b1;
                    n_mean   = (quotient[SUM_W-1:MEAN_W] != '0) ? {MEAN_W{1'b1}}
                                                                 : quotient[MEAN_W-1:0];
                    n_pcnt   = cnt_out;
                    n_status = ST_OK;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_mean   <= n_mean;
        r_pcnt   <= n_pcnt;
        r_status <= n_status;
        if (accept) begin
            r_op     <= i_operation;
            r_cls    <= i_class_label;
            r_band   <= i_band_index;
            r_sample <= i_sample;
            r_addr   <= ADDR_W'(32'(i_class_label) * BANDS + 32'(i_band_index));
        end
    end

    assign busy          = (r_state != S_IDLE);
    assign o_valid       = r_valid;
    assign o_mean_value  = r_mean;
    assign o_pixel_count = r_pcnt;
    assign o_status      = r_status;

    `CMSA_ASSERT_NOW(a_bad_status_zero, i_clk, i_rst_n, o_valid && (o_status != ST_OK), (o_mean_value == '0) && (o_pixel_count == '0))
    `CMSA_ASSERT_NOW(a_ok_nonempty, i_clk, i_rst_n, o_valid && (o_status == ST_OK), o_pixel_count != '0)
    `CMSA_ASSERT_NOW(a_clear_busy, i_clk, i_rst_n, r_state == S_CLEAR, busy && !o_valid)
    `CMSA_ASSERT_NEXT(a_range_read, i_clk, i_rst_n, accept && !in_range && (i_operation == OP_READ), o_valid && (o_status == ST_RANGE))

endmodule

`default_nettype wire
